// File: rtl/fcpa_pkg.sv
// Package for the fixed chunk pool allocator.
// Holds field widths, reset values, codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package fcpa_pkg;

  localparam int AddrWidth    = 32;
  localparam int SizeWidth    = 17;
  localparam int CountWidth   = 11;
  localparam int BytesWidth   = 27;
  localparam int ActionWidth  = 2;
  localparam int StatusWidth  = 2;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 32;

  localparam int DefMaxChunks = 1024;

  localparam logic [AddrWidth-1:0]  ResetBase       = '0;
  localparam logic [SizeWidth-1:0]  ResetChunkSize  = SizeWidth'(8);
  localparam logic [CountWidth-1:0] ResetChunkCount = CountWidth'(1024);

  typedef enum logic [ActionWidth-1:0] {
    ActAlloc = 2'd0,
    ActFree  = 2'd1,
    ActClear = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StSize  = 2'd2,
    StEmpty = 2'd3
  } status_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgBase  = 2'd0,
    CfgSize  = 2'd1,
    CfgCount = 2'd2,
    CfgSpare = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    StateIdle   = 1'b0,
    StateFinish = 1'b1
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    alloc_stack;
    logic    alloc_fresh;
    logic    push;
    logic    clear;
    logic    load_now;
    logic    load_finish;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic size_match;
    logic stack_empty;
    logic fresh_empty;
    logic used_low;
    logic stack_full;
  } flags_t;

endpackage

// File: rtl/fcpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the returned-address stack. No dependencies.
`timescale 1ns / 1ps

module fcpa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fcpa_ctrl.sv
// Controller of the fixed chunk pool allocator: handshake, state machine
// and command decode. Depends on fcpa_pkg.
`timescale 1ns / 1ps

module fcpa_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fcpa_pkg::ActionWidth-1:0]   in_action_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  fcpa_pkg::flags_t                   flags_i,
  output fcpa_pkg::cmd_t                     cmd_o
);

  fcpa_pkg::state_e  state_q, state_d;
  fcpa_pkg::action_e action;
  fcpa_pkg::cmd_t    cmd;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              accept;

  assign action    = fcpa_pkg::action_e'(in_action_i);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = (state_q == fcpa_pkg::StateIdle) && in_valid_i && slot_free;
  assign in_stall_o = !((state_q == fcpa_pkg::StateIdle) && slot_free);

  always_comb begin
    cmd        = '0;
    cmd.status = fcpa_pkg::StOk;
    case (state_q)
      fcpa_pkg::StateIdle: begin
        if (accept) begin
          cmd.accept = 1'b1;
          case (action)
            fcpa_pkg::ActAlloc: begin
              if (!flags_i.size_match) begin
                cmd.status   = fcpa_pkg::StSize;
                cmd.load_now = 1'b1;
              end else if (flags_i.stack_empty && flags_i.fresh_empty) begin
                cmd.status   = fcpa_pkg::StFull;
                cmd.load_now = 1'b1;
              end else if (!flags_i.stack_empty) begin
                cmd.alloc_stack = 1'b1;
              end else begin
                cmd.alloc_fresh = 1'b1;
              end
            end
            fcpa_pkg::ActFree: begin
              if (flags_i.used_low || flags_i.stack_full) begin
                cmd.status = fcpa_pkg::StEmpty;
              end else begin
                cmd.push = 1'b1;
              end
              cmd.load_now = 1'b1;
            end
            fcpa_pkg::ActClear: begin
              cmd.clear    = 1'b1;
              cmd.load_now = 1'b1;
            end
            default: begin
              cmd.load_now = 1'b1;
            end
          endcase
        end
      end
      fcpa_pkg::StateFinish: begin
        cmd.load_finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcpa_pkg::StateIdle: begin
        if (cmd.alloc_stack || cmd.alloc_fresh) begin
          state_d = fcpa_pkg::StateFinish;
        end
      end
      fcpa_pkg::StateFinish: begin
        state_d = fcpa_pkg::StateIdle;
      end
      default: begin
        state_d = fcpa_pkg::StateIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_now || cmd.load_finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcpa_pkg::StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: rtl/fcpa_dpath.sv
// Datapath of the fixed chunk pool allocator: configuration registers,
// counters, returned-address stack and result register.
// Depends on fcpa_pkg and fcpa_ram.
`timescale 1ns / 1ps

module fcpa_dpath #(
  parameter int MAX_CHUNKS = fcpa_pkg::DefMaxChunks
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcpa_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [fcpa_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic [fcpa_pkg::SizeWidth-1:0]      in_request_size_i,
  input  logic [fcpa_pkg::AddrWidth-1:0]      in_free_address_i,
  input  fcpa_pkg::cmd_t                      cmd_i,
  output fcpa_pkg::flags_t                    flags_o,
  output logic [fcpa_pkg::AddrWidth-1:0]      out_chunk_address_o,
  output logic [fcpa_pkg::StatusWidth-1:0]    out_status_o,
  output logic [fcpa_pkg::BytesWidth-1:0]     out_used_bytes_o,
  output logic [fcpa_pkg::BytesWidth-1:0]     out_peak_bytes_o
);

  localparam int AddrW   = fcpa_pkg::AddrWidth;
  localparam int SizeW   = fcpa_pkg::SizeWidth;
  localparam int CountW  = fcpa_pkg::CountWidth;
  localparam int BytesW  = fcpa_pkg::BytesWidth;
  localparam int IdxW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int DepthW  = $clog2(MAX_CHUNKS + 1);
  localparam int CountMax = (1 << CountW) - 1;
  localparam int FreshMax = (MAX_CHUNKS > CountMax) ? MAX_CHUNKS : CountMax;
  localparam int FreshW  = $clog2(FreshMax + 1);
  localparam int ProdW   = FreshW + SizeW;
  localparam int ResetCount = int'(fcpa_pkg::ResetChunkCount);
  localparam int FreshRst = (ResetCount == 0 || ResetCount > MAX_CHUNKS) ?
                            MAX_CHUNKS : ResetCount;

  logic [AddrW-1:0]  base_q;
  logic [SizeW-1:0]  csize_q;
  logic [CountW-1:0] ccount_q;

  logic [DepthW-1:0] depth_q, depth_d;
  logic [FreshW-1:0] fresh_q, fresh_d;
  logic [BytesW-1:0] used_q, used_d;
  logic [BytesW-1:0] peak_q, peak_d;
  logic [AddrW-1:0]  prod_q;
  logic              src_stack_q;

  logic [AddrW-1:0]  out_addr_q;
  fcpa_pkg::status_e out_status_q;
  logic [BytesW-1:0] out_used_q;
  logic [BytesW-1:0] out_peak_q;

  logic [BytesW:0]   used_sum;
  logic [BytesW-1:0] used_inc;
  logic [FreshW-1:0] fresh_dec;
  logic [ProdW-1:0]  prod_full;
  logic [FreshW-1:0] pool_chunks;
  logic [DepthW-1:0] depth_dec;
  logic [AddrW-1:0]  ram_rdata;
  logic [AddrW-1:0]  finish_addr;
  logic              count_odd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= fcpa_pkg::ResetBase;
      csize_q  <= fcpa_pkg::ResetChunkSize;
      ccount_q <= fcpa_pkg::ResetChunkCount;
    end else if (cfg_we_i) begin
      case (fcpa_pkg::cfg_idx_e'(cfg_index_i))
        fcpa_pkg::CfgBase:  base_q   <= cfg_data_i[AddrW-1:0];
        fcpa_pkg::CfgSize:  csize_q  <= cfg_data_i[SizeW-1:0];
        fcpa_pkg::CfgCount: ccount_q <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign flags_o.size_match  = (in_request_size_i == csize_q);
  assign flags_o.stack_empty = (depth_q == '0);
  assign flags_o.fresh_empty = (fresh_q == '0);
  assign flags_o.used_low    = (used_q < BytesW'(csize_q));
  assign flags_o.stack_full  = (depth_q >= DepthW'(MAX_CHUNKS));

  assign used_sum  = {1'b0, used_q} + (BytesW + 1)'(csize_q);
  assign used_inc  = used_sum[BytesW] ? '1 : used_sum[BytesW-1:0];
  assign fresh_dec = fresh_q - FreshW'(1);
  assign prod_full = ProdW'(fresh_dec) * ProdW'(csize_q);
  assign depth_dec = depth_q - DepthW'(1);

  assign count_odd   = (ccount_q == '0) || (32'(ccount_q) > 32'(MAX_CHUNKS));
  assign pool_chunks = count_odd ? FreshW'(MAX_CHUNKS) : FreshW'(ccount_q);

  always_comb begin
    depth_d = depth_q;
    fresh_d = fresh_q;
    used_d  = used_q;
    if (cmd_i.clear) begin
      depth_d = '0;
      fresh_d = pool_chunks;
      used_d  = '0;
    end else if (cmd_i.alloc_stack) begin
      depth_d = depth_dec;
      used_d  = used_inc;
    end else if (cmd_i.alloc_fresh) begin
      fresh_d = fresh_dec;
      used_d  = used_inc;
    end else if (cmd_i.push) begin
      depth_d = depth_q + DepthW'(1);
      used_d  = used_q - BytesW'(csize_q);
    end
  end

  always_comb begin
    peak_d = peak_q;
    if (cmd_i.clear) begin
      peak_d = '0;
    end else if (cmd_i.load_finish && (used_q > peak_q)) begin
      peak_d = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fresh_q <= FreshW'(FreshRst);
      used_q  <= '0;
      peak_q  <= '0;
    end else begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
      used_q  <= used_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prod_q      <= AddrW'(prod_full);
      src_stack_q <= cmd_i.alloc_stack;
    end
  end

  fcpa_ram #(
    .Width (AddrW),
    .Depth (MAX_CHUNKS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (depth_q[IdxW-1:0]),
    .wdata_i (in_free_address_i),
    .re_i    (cmd_i.alloc_stack),
    .raddr_i (depth_dec[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign finish_addr = src_stack_q ? ram_rdata : (base_q + prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      out_addr_q   <= '0;
      out_status_q <= cmd_i.status;
      out_used_q   <= used_d;
      out_peak_q   <= peak_d;
    end else if (cmd_i.load_finish) begin
      out_addr_q   <= finish_addr;
      out_status_q <= fcpa_pkg::StOk;
      out_used_q   <= used_q;
      out_peak_q   <= peak_d;
    end
  end

  assign out_chunk_address_o = out_addr_q;
  assign out_status_o        = out_status_q;
  assign out_used_bytes_o    = out_used_q;
  assign out_peak_bytes_o    = out_peak_q;

endmodule

// File: rtl/fixed_chunk_pool_allocator_unit.sv
// Top level of the fixed chunk pool allocator.
// Joins fcpa_ctrl and fcpa_dpath; depends on fcpa_pkg.
`timescale 1ns / 1ps

// Hands out fixed-size chunks in last-in-first-out order: a freed address is
// granted again first, otherwise untouched chunks are granted from the highest
// index down. One request is worked at a time. Free, reset-pool, rejected and
// unknown requests load the result register on acceptance; a granted allocate
// passes the finish state, as its address comes either from the registered read
// of the returned-address stack RAM or from the registered chunk offset multiply.
// A result that waits under stall holds the input stalled; the next request
// enters in the cycle that result is taken.
// The stack RAM needs no clearing after reset; the block is ready at once.
module fixed_chunk_pool_allocator_unit #(
  parameter int MAX_CHUNKS = fcpa_pkg::DefMaxChunks
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcpa_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [fcpa_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fcpa_pkg::ActionWidth-1:0]    in_action_i,
  input  logic [fcpa_pkg::SizeWidth-1:0]      in_request_size_i,
  input  logic [fcpa_pkg::AddrWidth-1:0]      in_free_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fcpa_pkg::AddrWidth-1:0]      out_chunk_address_o,
  output logic [fcpa_pkg::StatusWidth-1:0]    out_status_o,
  output logic [fcpa_pkg::BytesWidth-1:0]     out_used_bytes_o,
  output logic [fcpa_pkg::BytesWidth-1:0]     out_peak_bytes_o
);

  fcpa_pkg::cmd_t   cmd;
  fcpa_pkg::flags_t flags;

  fcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_action_i (in_action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  fcpa_dpath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_request_size_i   (in_request_size_i),
    .in_free_address_i   (in_free_address_i),
    .cmd_i               (cmd),
    .flags_o             (flags),
    .out_chunk_address_o (out_chunk_address_o),
    .out_status_o        (out_status_o),
    .out_used_bytes_o    (out_used_bytes_o),
    .out_peak_bytes_o    (out_peak_bytes_o)
  );

endmodule

// File: sim/fcpa_checker.sv
// Scoreboard for the fixed chunk pool allocator: tracks config writes, predicts each result
// beat from the request beats it sees and compares the two field by field.
// Depends on fcpa_pkg.
`timescale 1ns / 1ps

module fcpa_checker
  import fcpa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [ActionWidth-1:0]  in_action_i,
  input  logic [SizeWidth-1:0]    in_request_size_i,
  input  logic [AddrWidth-1:0]    in_free_address_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [AddrWidth-1:0]    out_chunk_address_i,
  input  logic [StatusWidth-1:0]  out_status_i,
  input  logic [BytesWidth-1:0]   out_used_bytes_i,
  input  logic [BytesWidth-1:0]   out_peak_bytes_i,
  output int                      mismatches_o,
  output int                      pending_o
);

  localparam int          MaxChunks = DefMaxChunks;
  localparam int unsigned BytesMax  = (1 << BytesWidth) - 1;
  localparam int          ReportCap = 100;

  typedef struct packed {
    logic [AddrWidth-1:0]  addr;
    status_e               status;
    logic [BytesWidth-1:0] used;
    logic [BytesWidth-1:0] peak;
  } grant_t;

  logic [AddrWidth-1:0]  pool_base;
  logic [SizeWidth-1:0]  chunk_bytes;
  logic [CountWidth-1:0] chunk_total;
  logic [AddrWidth-1:0]  returned_mem [MaxChunks];
  int unsigned           returned_top;
  int unsigned           fresh_left;
  int unsigned           used_bytes;
  int unsigned           peak_bytes;
  grant_t                due_grants [$];

  function automatic void clear_pool();
    returned_top = 0;
    if (chunk_total == 0 || chunk_total > MaxChunks) fresh_left = MaxChunks;
    else fresh_left = chunk_total;
    used_bytes = 0;
    peak_bytes = 0;
  endfunction

  function automatic grant_t predict_grant(action_e act, logic [SizeWidth-1:0] rsize,
                                           logic [AddrWidth-1:0] faddr);
    grant_t          g;
    longint unsigned offset;
    g = '0;
    g.status = StOk;
    case (act)
      ActAlloc: begin
        if (rsize != chunk_bytes) begin
          g.status = StSize;
        end else if (returned_top == 0 && fresh_left == 0) begin
          g.status = StFull;
        end else begin
          if (returned_top > 0) begin
            returned_top--;
            g.addr = returned_mem[returned_top];
          end else begin
            fresh_left--;
            offset = 64'(fresh_left) * 64'(chunk_bytes);
            g.addr = pool_base + offset[AddrWidth-1:0];
          end
          used_bytes = used_bytes + chunk_bytes;
          if (used_bytes > BytesMax) used_bytes = BytesMax;
          if (used_bytes > peak_bytes) peak_bytes = used_bytes;
        end
      end
      ActFree: begin
        if (used_bytes < chunk_bytes || returned_top >= MaxChunks) begin
          g.status = StEmpty;
        end else begin
          used_bytes = used_bytes - chunk_bytes;
          returned_mem[returned_top] = faddr;
          returned_top++;
        end
      end
      ActClear: clear_pool();
      default: ;
    endcase
    g.used = used_bytes[BytesWidth-1:0];
    g.peak = peak_bytes[BytesWidth-1:0];
    return g;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      mismatches_o++;
      if (mismatches_o <= ReportCap) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      pool_base    = ResetBase;
      chunk_bytes  = ResetChunkSize;
      chunk_total  = ResetChunkCount;
      clear_pool();
      due_grants.delete();
      mismatches_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_grants.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportCap) $error("result beat with no request outstanding");
        end else begin
          want = due_grants.pop_front();
          compare_field("chunk_address", want.addr, out_chunk_address_i);
          compare_field("status", want.status, out_status_i);
          compare_field("used_bytes", want.used, out_used_bytes_i);
          compare_field("peak_bytes", want.peak, out_peak_bytes_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_grants.push_back(predict_grant(action_e'(in_action_i), in_request_size_i,
                                           in_free_address_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgBase:  pool_base = cfg_data_i[AddrWidth-1:0];
          CfgSize:  chunk_bytes = cfg_data_i[SizeWidth-1:0];
          CfgCount: chunk_total = cfg_data_i[CountWidth-1:0];
          default: ;
        endcase
      end
    end
    pending_o = due_grants.size();
  end

endmodule

// File: sim/tb_fixed_chunk_pool_allocator_unit.sv
// Testbench top for fixed_chunk_pool_allocator_unit: clock, reset, request and config
// stimulus, random stalls on the result side, watchdog and verdict.
// Depends on fcpa_pkg, fcpa_checker and the allocator RTL.
`timescale 1ns / 1ps

module tb_fixed_chunk_pool_allocator_unit;
  import fcpa_pkg::*;

  localparam int StallLimit = 2000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ActionWidth-1:0]  in_action = '0;
  logic [SizeWidth-1:0]    in_request_size = '0;
  logic [AddrWidth-1:0]    in_free_address = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [AddrWidth-1:0]    out_chunk_address;
  logic [StatusWidth-1:0]  out_status;
  logic [BytesWidth-1:0]   out_used_bytes;
  logic [BytesWidth-1:0]   out_peak_bytes;
  logic                    steady = 1'b0;
  int                      mismatches;
  int                      pending;
  int                      quiet_cycles = 0;

  always #4 clk = ~clk;

  fixed_chunk_pool_allocator_unit u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_action_i         (in_action),
    .in_request_size_i   (in_request_size),
    .in_free_address_i   (in_free_address),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_chunk_address_o (out_chunk_address),
    .out_status_o        (out_status),
    .out_used_bytes_o    (out_used_bytes),
    .out_peak_bytes_o    (out_peak_bytes)
  );

  fcpa_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_action_i         (in_action),
    .in_request_size_i   (in_request_size),
    .in_free_address_i   (in_free_address),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_chunk_address_i (out_chunk_address),
    .out_status_i        (out_status),
    .out_used_bytes_i    (out_used_bytes),
    .out_peak_bytes_i    (out_peak_bytes),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("** fixed_chunk_pool_allocator_unit: FAILED **");
      $finish;
    end
  end

  task automatic issue_request(action_e act, logic [SizeWidth-1:0] rsize,
                               logic [AddrWidth-1:0] faddr);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_request_size <= rsize;
    in_free_address <= faddr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pool_setup(logic [CfgDataWidth-1:0] base, logic [CfgDataWidth-1:0] size,
                                 logic [CfgDataWidth-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CfgBase;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CfgSize;
    cfg_data  <= size;
    @(posedge clk);
    cfg_index <= CfgCount;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_mixed_traffic(int beats, logic [AddrWidth-1:0] base,
                                   logic [SizeWidth-1:0] csize, int count);
    int unsigned pick;
    load_pool_setup(base, csize, count);
    issue_request(ActClear, SizeWidth'($urandom), $urandom);
    repeat (beats) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        issue_request(ActAlloc, csize, $urandom);
      end else if (pick < 62) begin
        issue_request(ActFree, SizeWidth'($urandom),
                      base + AddrWidth'($urandom_range(0, 63)) * csize);
      end else if (pick < 80) begin
        issue_request(ActFree, SizeWidth'($urandom), $urandom);
      end else if (pick < 87) begin
        issue_request(ActAlloc, SizeWidth'($urandom_range(0, 17'h1FFFF)), $urandom);
      end else if (pick < 94) begin
        issue_request(ActNone, SizeWidth'($urandom), $urandom);
      end else begin
        issue_request(ActClear, SizeWidth'($urandom), $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [AddrWidth-1:0] base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: base zero, 8-byte chunks, full pool
    issue_request(ActAlloc, 17'd8, $urandom);
    issue_request(ActFree, 17'd8, 32'hFFFF_FFFF);
    issue_request(ActAlloc, 17'd8, 32'h0);
    wait_drained();

    // tiny pool that wraps the address space
    load_pool_setup(32'hFFFF_FFF0, 32'd8, 32'd4);
    issue_request(ActClear, 17'd0, 32'h0);
    issue_request(ActAlloc, 17'd7, 32'h0);
    issue_request(ActAlloc, 17'h1FFFF, 32'h0);
    issue_request(ActFree, 17'd8, 32'h1234_5678);
    repeat (4) issue_request(ActAlloc, 17'd8, 32'h0);
    issue_request(ActAlloc, 17'd8, 32'hFFFF_FFFF);
    issue_request(ActFree, 17'd0, 32'hFFFF_FFFF);
    issue_request(ActFree, 17'h1FFFF, 32'h0);
    issue_request(ActAlloc, 17'd8, 32'h0);
    issue_request(ActNone, 17'h1FFFF, 32'hFFFF_FFFF);
    issue_request(ActAlloc, 17'd8, 32'h0);
    issue_request(ActAlloc, 17'd0, 32'h0);
    issue_request(ActClear, SizeWidth'($urandom), $urandom);
    issue_request(ActAlloc, 17'd8, 32'h0);
    issue_request(ActNone, 17'd0, 32'h0);
    wait_drained();

    // fill a small pool past full, then return every chunk and free past empty
    steady <= 1'b1;
    base = $urandom;
    load_pool_setup(base, 32'd65536, 32'd128);
    issue_request(ActClear, 17'd0, 32'h0);
    repeat (130) issue_request(ActAlloc, 17'd65536, $urandom);
    repeat (130) issue_request(ActFree, SizeWidth'($urandom), $urandom);
    wait_drained();

    run_mixed_traffic(70, 32'h0, 17'd65536, 1024);
    steady <= 1'b0;
    run_mixed_traffic(70, $urandom, 17'd8, 1);
    run_mixed_traffic(70, 32'hFFFF_FFFF, SizeWidth'($urandom_range(8, 65536)),
                      $urandom_range(1, 16));
    run_mixed_traffic(70, $urandom, 17'd24, 0);
    run_mixed_traffic(70, $urandom, SizeWidth'($urandom_range(8, 4096)), 2047);
    run_mixed_traffic(70, $urandom, SizeWidth'($urandom_range(8, 256)),
                      $urandom_range(2, 32));

    if (mismatches == 0 && pending == 0) begin
      $display("** fixed_chunk_pool_allocator_unit: PASSED **");
    end else begin
      $display("** fixed_chunk_pool_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fcpa_pkg.sv
rtl/fcpa_ram.sv
rtl/fcpa_ctrl.sv
rtl/fcpa_dpath.sv
rtl/fixed_chunk_pool_allocator_unit.sv
sim/fcpa_checker.sv
sim/tb_fixed_chunk_pool_allocator_unit.sv
